>>> rtl/met_pkg.sv
package met_pkg;

  localparam int NUM_SLOTS  = 31;
  localparam int COUNT_BITS = 32;
  localparam int CNT_W      = $clog2(NUM_SLOTS + 1);

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [CNT_W-1:0]      rank_t;

  typedef enum logic [2:0] {
    KIND_ALLOC = 3'd0,
    KIND_FREE  = 3'd1,
    KIND_ARM   = 3'd2,
    KIND_QUERY = 3'd3,
    KIND_ADV   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ALLOC,
    OP_FREE,
    OP_DISARM,
    OP_ARM,
    OP_SUB,
    OP_POP
  } op_t;

  typedef enum logic [1:0] {
    SCAN_FREE,
    SCAN_LE,
    SCAN_ZERO
  } scan_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIS,
    ST_SCAN0,
    ST_SCAN,
    ST_ALLOC,
    ST_ARM,
    ST_QRY,
    ST_SUB,
    ST_LOOK,
    ST_FIRE
  } state_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    op_t    op;
    scan_t  scan;
    logic   dec;
    count_t value;
    rank_t  rank;
  } cmd_t;

  // Status a cell shows to the controller.
  typedef struct packed {
    logic   alloc;
    logic   armed;
    count_t deadline;
    rank_t  rank;
    logic   hit;
    logic   head;
    logic   rank_hit;
  } cell_st_t;

  function automatic count_t to_count(input logic [31:0] a);
    count_t r;
    r = '0;
    for (int i = 0; i < COUNT_BITS; i++) begin
      if (i < 32) r[i] = a[i % 32];
    end
    return r;
  endfunction

  function automatic logic [31:0] to_out32(input count_t a);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (i < COUNT_BITS) r[i] = a[i % COUNT_BITS];
    end
    return r;
  endfunction

  function automatic count_t sat_add(input count_t a, input count_t b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
  endfunction

  // Slot number (index plus one), low five bits.
  function automatic logic [4:0] slot5(input rank_t idx);
    logic [CNT_W:0] s;
    logic [4:0]     r;
    s = {1'b0, idx} + 1'b1;
    r = '0;
    for (int i = 0; i < 5; i++) begin
      if (i <= CNT_W) r[i] = s[i % (CNT_W + 1)];
    end
    return r;
  endfunction

endpackage

>>> rtl/met_cell.sv
module met_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  met_pkg::cmd_t     cmd,
  input  logic              sel,
  input  logic              tok_in,
  output logic              tok_out,
  output met_pkg::cell_st_t st
);

  logic            alloc_r, alloc_nxt;
  logic            armed_r, armed_nxt;
  met_pkg::count_t deadline_r, deadline_nxt;
  met_pkg::rank_t  rank_r, rank_nxt;
  logic            tok_r;
  logic            flag;

  always_comb begin
    unique case (cmd.scan)
      met_pkg::SCAN_FREE: flag = !alloc_r;
      met_pkg::SCAN_LE:   flag = armed_r && (deadline_r <= cmd.value);
      met_pkg::SCAN_ZERO: flag = armed_r && (deadline_r == '0);
      default:            flag = 1'b0;
    endcase
  end

  always_comb begin
    alloc_nxt    = alloc_r;
    armed_nxt    = armed_r;
    deadline_nxt = deadline_r;
    rank_nxt     = rank_r;
    unique case (cmd.op)
      met_pkg::OP_ALLOC: begin
        if (sel) alloc_nxt = 1'b1;
      end
      met_pkg::OP_FREE, met_pkg::OP_DISARM: begin
        if (sel) begin
          armed_nxt    = 1'b0;
          deadline_nxt = '0;
          rank_nxt     = '0;
          if (cmd.op == met_pkg::OP_FREE) alloc_nxt = 1'b0;
        end else if (cmd.dec && armed_r && (rank_r > cmd.rank)) begin
          rank_nxt = rank_r - 1'b1;
        end
      end
      met_pkg::OP_ARM: begin
        if (sel) begin
          armed_nxt    = 1'b1;
          deadline_nxt = cmd.value;
          rank_nxt     = cmd.rank;
        end else if (armed_r && (deadline_r > cmd.value)) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
      met_pkg::OP_SUB: begin
        if (armed_r) deadline_nxt = deadline_r - cmd.value;
      end
      met_pkg::OP_POP: begin
        // The head leaves the queue and everyone behind it moves up.
        if (armed_r) begin
          if (rank_r == '0) begin
            armed_nxt    = 1'b0;
            deadline_nxt = '0;
          end else begin
            rank_nxt = rank_r - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_r    <= 1'b0;
      armed_r    <= 1'b0;
      deadline_r <= '0;
      rank_r     <= '0;
      tok_r      <= 1'b0;
    end else begin
      alloc_r    <= alloc_nxt;
      armed_r    <= armed_nxt;
      deadline_r <= deadline_nxt;
      rank_r     <= rank_nxt;
      tok_r      <= tok_in;
    end
  end

  assign tok_out     = tok_r;
  assign st.alloc    = alloc_r;
  assign st.armed    = armed_r;
  assign st.deadline = deadline_r;
  assign st.rank     = rank_r;
  assign st.hit      = tok_r && flag;
  assign st.head     = armed_r && (rank_r == '0);
  assign st.rank_hit = armed_r && (rank_r == cmd.rank);

endmodule

>>> rtl/multi_slot_event_timer.sv
// Channel  | Ports                                         | Transfer
// ---------+-----------------------------------------------+---------------------------
// command  | start, busy, in_kind, in_slot, in_amount      | start high while busy low
// result   | out_strobe, out_slot_out .. out_last           | out_strobe high, one cycle
//
// Allocate, an arm with a nonzero amount and an advance that expires a slot pass a scan
// token along the chain of slot cells; a query, a free or a zero-amount arm does not.
// An ignored free or arm, or an unused kind, goes straight back to idle with no result.
// An advance gives each fired slot as a result of its own.
// Reset is synchronous and active low; it clears every slot and elapsed time.
// Results appear one per cycle and the receiver cannot stall them.
module multi_slot_event_timer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [4:0]  in_slot,
  input  logic [31:0] in_amount,
  output logic        out_strobe,
  output logic [4:0]  out_slot_out,
  output logic        out_valid_res,
  output logic [31:0] out_remaining,
  output logic        out_fired,
  output logic        out_more_pending,
  output logic        out_last
);

  localparam int N = met_pkg::NUM_SLOTS;

  met_pkg::state_t   state_r, state_nxt;
  met_pkg::kind_t    kind_r;
  met_pkg::scan_t    scan_r;
  met_pkg::rank_t    tgt_r, cnt_r, scan_i_r, nfire_r;
  met_pkg::count_t   elapsed_r, when_r;
  logic              rng_r, amt_nz_r, qhead_r, found_r, more_r;

  met_pkg::cmd_t     cmd;
  met_pkg::cell_st_t st_w [N];
  logic [N:0]        tok_w;
  logic [N-1:0]      sel_w;
  logic [N-1:0]      alloc_v;
  logic              tok_inj;

  logic              in_rng;
  met_pkg::rank_t    in_idx;
  met_pkg::count_t   amt_c;

  logic              hd_any, sl_armed, rk_any, hit_any, q_ok;
  met_pkg::count_t   hd_dl, sl_dl, rk_dl, q_dl;
  met_pkg::rank_t    hd_idx, sl_rank;

  assign tok_w[0] = tok_inj;

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign sel_w[i]   = (tgt_r == met_pkg::rank_t'(i));
    assign alloc_v[i] = st_w[i].alloc;
    met_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .sel     (sel_w[i]),
      .tok_in  (tok_w[i]),
      .tok_out (tok_w[i+1]),
      .st      (st_w[i])
    );
  end

  assign amt_c  = met_pkg::to_count(in_amount);
  assign in_rng = (in_slot != 5'd0) && ({27'd0, in_slot} <= 32'(N));
  assign in_idx = met_pkg::rank_t'(in_slot - 5'd1);

  always_comb begin
    hd_any   = 1'b0;
    hd_dl    = '0;
    hd_idx   = '0;
    sl_armed = 1'b0;
    sl_dl    = '0;
    sl_rank  = '0;
    rk_any   = 1'b0;
    rk_dl    = '0;
    hit_any  = 1'b0;
    for (int i = 0; i < N; i++) begin
      hit_any = hit_any | st_w[i].hit;
      if (st_w[i].head) begin
        hd_any = 1'b1;
        hd_dl  = hd_dl | st_w[i].deadline;
        hd_idx = hd_idx | met_pkg::rank_t'(i);
      end
      if (sel_w[i]) begin
        sl_armed = st_w[i].armed;
        sl_dl    = st_w[i].deadline;
        sl_rank  = st_w[i].rank;
      end
      if (st_w[i].rank_hit) begin
        rk_any = 1'b1;
        rk_dl  = rk_dl | st_w[i].deadline;
      end
    end
  end

  assign q_ok = qhead_r ? hd_any : (rng_r && sl_armed);
  assign q_dl = qhead_r ? hd_dl : sl_dl;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      met_pkg::ST_IDLE: begin
        if (start) begin
          unique case (in_kind)
            met_pkg::KIND_ALLOC: state_nxt = met_pkg::ST_SCAN0;
            met_pkg::KIND_FREE:  state_nxt = in_rng ? met_pkg::ST_DIS : met_pkg::ST_IDLE;
            met_pkg::KIND_ARM:
              state_nxt = (in_rng && alloc_v[in_idx]) ? met_pkg::ST_DIS : met_pkg::ST_IDLE;
            met_pkg::KIND_QUERY: state_nxt = met_pkg::ST_QRY;
            met_pkg::KIND_ADV:   state_nxt = met_pkg::ST_SUB;
            default:             state_nxt = met_pkg::ST_IDLE;
          endcase
        end
      end
      met_pkg::ST_DIS:
        state_nxt = (kind_r == met_pkg::KIND_ARM && amt_nz_r) ? met_pkg::ST_SCAN0
                                                              : met_pkg::ST_IDLE;
      met_pkg::ST_SCAN0: state_nxt = met_pkg::ST_SCAN;
      met_pkg::ST_SCAN: begin
        if (tok_w[N]) begin
          unique case (scan_r)
            met_pkg::SCAN_FREE: state_nxt = met_pkg::ST_ALLOC;
            met_pkg::SCAN_LE:   state_nxt = met_pkg::ST_ARM;
            default:            state_nxt = met_pkg::ST_LOOK;
          endcase
        end
      end
      met_pkg::ST_ALLOC: state_nxt = met_pkg::ST_IDLE;
      met_pkg::ST_ARM:   state_nxt = met_pkg::ST_IDLE;
      met_pkg::ST_QRY:   state_nxt = met_pkg::ST_IDLE;
      met_pkg::ST_SUB:
        state_nxt = (hd_any && elapsed_r >= hd_dl) ? met_pkg::ST_SCAN0 : met_pkg::ST_IDLE;
      met_pkg::ST_LOOK:  state_nxt = met_pkg::ST_FIRE;
      met_pkg::ST_FIRE:
        state_nxt = (nfire_r == met_pkg::rank_t'(1)) ? met_pkg::ST_IDLE : met_pkg::ST_FIRE;
      default: state_nxt = met_pkg::ST_IDLE;
    endcase
  end

  // Commands to the cell chain.
  always_comb begin
    cmd.op    = met_pkg::OP_NONE;
    cmd.scan  = scan_r;
    cmd.dec   = 1'b0;
    cmd.value = when_r;
    cmd.rank  = cnt_r;
    tok_inj   = 1'b0;
    unique case (state_r)
      met_pkg::ST_DIS: begin
        cmd.op   = (kind_r == met_pkg::KIND_FREE) ? met_pkg::OP_FREE : met_pkg::OP_DISARM;
        cmd.dec  = sl_armed;
        cmd.rank = sl_rank;
      end
      met_pkg::ST_SCAN0: tok_inj = 1'b1;
      met_pkg::ST_ALLOC: cmd.op = found_r ? met_pkg::OP_ALLOC : met_pkg::OP_NONE;
      met_pkg::ST_ARM:   cmd.op = met_pkg::OP_ARM;
      met_pkg::ST_SUB: begin
        if (hd_any && elapsed_r >= hd_dl) begin
          cmd.op    = met_pkg::OP_SUB;
          cmd.value = hd_dl;
        end
      end
      met_pkg::ST_FIRE:  cmd.op = met_pkg::OP_POP;
      default: begin
      end
    endcase
  end

  assign busy = (state_r != met_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= met_pkg::ST_IDLE;
      elapsed_r  <= '0;
      out_strobe <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      out_strobe <= 1'b0;
      unique case (state_r)
        met_pkg::ST_IDLE: begin
          if (start) begin
            kind_r   <= met_pkg::kind_t'(in_kind);
            tgt_r    <= in_idx;
            rng_r    <= in_rng;
            qhead_r  <= (in_slot == 5'd0);
            amt_nz_r <= (amt_c != '0);
            when_r   <= met_pkg::sat_add(elapsed_r, amt_c);
            if (in_kind == met_pkg::KIND_ALLOC) scan_r <= met_pkg::SCAN_FREE;
            if (in_kind == met_pkg::KIND_ARM)   scan_r <= met_pkg::SCAN_LE;
            if (in_kind == met_pkg::KIND_ADV)
              elapsed_r <= met_pkg::sat_add(elapsed_r, amt_c);
          end
        end
        met_pkg::ST_SCAN0: begin
          cnt_r    <= '0;
          scan_i_r <= '0;
          found_r  <= 1'b0;
        end
        met_pkg::ST_SCAN: begin
          scan_i_r <= scan_i_r + 1'b1;
          if (hit_any) cnt_r <= cnt_r + 1'b1;
          // The first free slot seen along the chain is the lowest one.
          if (hit_any && !found_r && scan_r == met_pkg::SCAN_FREE) begin
            found_r <= 1'b1;
            tgt_r   <= scan_i_r;
          end
        end
        met_pkg::ST_ALLOC: begin
          out_strobe       <= 1'b1;
          out_slot_out     <= found_r ? met_pkg::slot5(tgt_r) : 5'd0;
          out_valid_res    <= found_r;
          out_remaining    <= '0;
          out_fired        <= 1'b0;
          out_more_pending <= 1'b0;
          out_last         <= 1'b1;
        end
        met_pkg::ST_QRY: begin
          out_strobe       <= 1'b1;
          out_slot_out     <= 5'd0;
          out_valid_res    <= q_ok;
          out_remaining    <= (q_ok && q_dl > elapsed_r) ?
                              met_pkg::to_out32(q_dl - elapsed_r) : 32'd0;
          out_fired        <= 1'b0;
          out_more_pending <= 1'b0;
          out_last         <= 1'b1;
        end
        met_pkg::ST_SUB: begin
          if (!hd_any) begin
            elapsed_r <= '0;
          end else if (elapsed_r >= hd_dl) begin
            elapsed_r <= elapsed_r - hd_dl;
            scan_r    <= met_pkg::SCAN_ZERO;
          end
        end
        met_pkg::ST_LOOK: begin
          // The cell ranked just behind the fired group decides whether
          // another expiry is already due.
          more_r  <= rk_any && (rk_dl <= elapsed_r);
          nfire_r <= cnt_r;
        end
        met_pkg::ST_FIRE: begin
          out_strobe       <= 1'b1;
          out_slot_out     <= met_pkg::slot5(hd_idx);
          out_valid_res    <= 1'b0;
          out_remaining    <= '0;
          out_fired        <= 1'b1;
          out_more_pending <= more_r;
          out_last         <= (nfire_r == met_pkg::rank_t'(1));
          nfire_r          <= nfire_r - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
